// ===== sv/fqs_pkg.sv =====
// shared types and constants for the searchable fifo queue
// no dependencies; every other file imports this package
package fqs_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned DEFAULT_DEPTH = 16;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_DUMP   = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_POPPED    = 3'd2,
    ST_POP_EMPTY = 3'd3,
    ST_LISTED    = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FOUND     = 3'd6,
    ST_NOT_FOUND = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_MARK
  } bk_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  data;
    logic [POS_W-1:0]   position;
    logic               now_empty;
    logic               last;
  } res_t;

endpackage

// ===== sv/fqs_front.sv =====
// front end: accepts command transactions, drops unknown codes and
// buffers the rest in a two-entry command queue; depends on fqs_pkg
module fqs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [2:0]             cmd_i,
  input  logic [31:0]            value_i,
  output logic                   cq_valid_o,
  output fqs_pkg::cmd_t          cq_item_o,
  input  logic                   cq_take_i
);
  import fqs_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic       known;
  logic       we;

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;
  // codes above search cause nothing, so they never enter the queue
  assign known  = (cmd_i <= CMD_SEARCH);
  assign we     = accept && known;

  assign cq_valid_o = (cnt_q != 2'd0);
  assign cq_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ we;
    rd_ptr_d = rd_ptr_q ^ cq_take_i;
    case ({we, cq_take_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_q[wr_ptr_q] <= '{cmd: cmd_e'(cmd_i), value: value_i};
    end
  end

endmodule

// ===== sv/fqs_res_q.sv =====
// two-entry result queue between the back end and the result ports
// depends on fqs_pkg for the result record
module fqs_res_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  fqs_pkg::res_t item_i,
  output logic          full_o,
  output logic          empty,
  input  logic          pop,
  output fqs_pkg::res_t item_o
);
  import fqs_pkg::*;

  res_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       re;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign re     = pop && !empty;
  assign item_o = slot_q[rd_ptr_q];

  always_comb begin
    case ({we_i, re})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ we_i;
      rd_ptr_q <= rd_ptr_q ^ re;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/fqs_back.sv =====
// back end: ring store with head, tail and count, and the sequencer that
// carries out each command one entry at a time; depends on fqs_pkg
module fqs_back #(
  parameter int unsigned DEPTH = fqs_pkg::DEFAULT_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cq_valid_i,
  input  fqs_pkg::cmd_t cq_item_i,
  output logic          cq_take_o,
  output logic          res_we_o,
  output fqs_pkg::res_t res_o,
  input  logic          res_full_i
);
  import fqs_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  bk_state_e         state_q, state_d;
  cmd_e              op_q, op_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  step_q, step_d;

  logic              start;
  logic              mem_we;
  logic              rd_en;
  logic [CNT_W-1:0]  step_inc;
  logic              walk_end;
  logic              hit;
  logic              is_empty;

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
    nxt = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign start     = (state_q == BK_IDLE) && cq_valid_i && !res_full_i;
  assign cq_take_o = start;
  assign is_empty  = (count_q == '0);
  assign step_inc  = step_q + 1'b1;
  assign walk_end  = (step_inc == count_q);
  assign hit       = (rd_data_q == key_q);
  assign rd_en     = (state_q == BK_READ);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start && !is_empty && cq_item_i.cmd != CMD_PUSH) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_EVAL;
      BK_EVAL: begin
        if (!res_full_i) begin
          unique case (op_q)
            CMD_CLEAR:  state_d = (count_q == CNT_W'(1)) ? BK_MARK : BK_READ;
            CMD_DUMP:   state_d = walk_end ? BK_IDLE : BK_READ;
            CMD_SEARCH: state_d = (hit || walk_end) ? BK_IDLE : BK_READ;
            default:    state_d = BK_IDLE;
          endcase
        end
      end
      BK_MARK: begin
        if (!res_full_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and result generation
  always_comb begin
    op_d     = op_q;
    key_d    = key_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    idx_d    = idx_q;
    step_d   = step_q;
    mem_we   = 1'b0;
    res_we_o = 1'b0;
    res_o    = '{status: ST_PUSHED, data: '0, position: '0, now_empty: 1'b0, last: 1'b1};
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          op_d  = cq_item_i.cmd;
          key_d = cq_item_i.value;
          idx_d = head_q;
          step_d = '0;
          unique case (cq_item_i.cmd)
            CMD_PUSH: begin
              res_we_o = 1'b1;
              if (count_q >= FULL_CNT) begin
                res_o.status    = ST_FULL;
                res_o.now_empty = is_empty;
              end else begin
                mem_we  = 1'b1;
                tail_d  = nxt(tail_q);
                count_d = count_q + 1'b1;
              end
            end
            CMD_POP: begin
              if (is_empty) begin
                res_we_o        = 1'b1;
                res_o.status    = ST_POP_EMPTY;
                res_o.now_empty = 1'b1;
              end
            end
            CMD_CLEAR, CMD_DUMP: begin
              if (is_empty) begin
                res_we_o        = 1'b1;
                res_o.status    = ST_EMPTY;
                res_o.now_empty = 1'b1;
                head_d          = '0;
                tail_d          = '0;
              end
            end
            default: begin
              if (is_empty) begin
                res_we_o        = 1'b1;
                res_o.status    = ST_NOT_FOUND;
                res_o.now_empty = 1'b1;
              end
            end
          endcase
        end
      end
      BK_READ: ;
      BK_EVAL: begin
        if (!res_full_i) begin
          idx_d  = nxt(idx_q);
          step_d = step_inc;
          unique case (op_q)
            CMD_POP, CMD_CLEAR: begin
              res_we_o        = 1'b1;
              res_o.status    = ST_POPPED;
              res_o.data      = rd_data_q;
              res_o.now_empty = (count_q == CNT_W'(1));
              res_o.last      = (op_q == CMD_POP);
              head_d          = nxt(head_q);
              count_d         = count_q - 1'b1;
            end
            CMD_DUMP: begin
              res_we_o     = 1'b1;
              res_o.status = ST_LISTED;
              res_o.data   = rd_data_q;
              res_o.last   = walk_end;
            end
            default: begin
              if (hit) begin
                res_we_o       = 1'b1;
                res_o.status   = ST_FOUND;
                res_o.position = POS_W'(step_inc);
              end else if (walk_end) begin
                res_we_o     = 1'b1;
                res_o.status = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      BK_MARK: begin
        if (!res_full_i) begin
          res_we_o        = 1'b1;
          res_o.status    = ST_EMPTY;
          res_o.now_empty = 1'b1;
          head_d          = '0;
          tail_d          = '0;
          count_d         = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      op_q    <= CMD_PUSH;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // ring store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= cq_item_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

endmodule

// ===== sv/fifo_queue_with_search.sv =====
// searchable fifo queue: push and the empty cases are answered in the idle state;
// pop passes through the read and eval states; clear, dump and search repeat read
// and eval for each entry walked through the ring store, clear ending in the mark state.
// each result goes through the result queue to the ports; a search stops at its first hit.
// reset empties both queues and the ring; stored words are not cleared.
module fifo_queue_with_search #(
  parameter int unsigned DEPTH = fqs_pkg::DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [31:0] data_out_o,
  output logic [5:0]  position_o,
  output logic        now_empty_o,
  output logic        last_o
);
  import fqs_pkg::*;

  logic cq_valid;
  cmd_t cq_item;
  logic cq_take;
  logic res_we;
  res_t res_in;
  logic res_full;
  res_t res_out;

  fqs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .cq_valid_o (cq_valid),
    .cq_item_o  (cq_item),
    .cq_take_i  (cq_take)
  );

  fqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cq_valid_i (cq_valid),
    .cq_item_i  (cq_item),
    .cq_take_o  (cq_take),
    .res_we_o   (res_we),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  fqs_res_q u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (res_we),
    .item_i (res_in),
    .full_o (res_full),
    .empty  (empty),
    .pop    (pop),
    .item_o (res_out)
  );

  assign status_o    = res_out.status;
  assign data_out_o  = res_out.data;
  assign position_o  = res_out.position;
  assign now_empty_o = res_out.now_empty;
  assign last_o      = res_out.last;

endmodule
